@@ rtl/char_bitmap_cell_pixel_generator_core_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef CHAR_BITMAP_CELL_PIXEL_GENERATOR_CORE_MACROS_SVH
`define CHAR_BITMAP_CELL_PIXEL_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbpg assertion failed");

// Next-cycle implication, checked outside reset.
`define CBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpg assertion failed");

`endif

@@ rtl/cbpg_pkg.sv @@
package cbpg_pkg;

  localparam int unsigned NUM_PIXELS = 8;
  localparam int unsigned PIX_IDX_W  = 3;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned COL_W      = 9;

  // Graphics modes
  localparam logic [2:0] MODE_TEXT       = 3'd0;
  localparam logic [2:0] MODE_MC_TEXT    = 3'd1;
  localparam logic [2:0] MODE_EXT_BG     = 3'd2;
  localparam logic [2:0] MODE_BITMAP     = 3'd3;
  localparam logic [2:0] MODE_MC_BITMAP  = 3'd4;
  localparam logic [2:0] MODE_BAD_TEXT   = 3'd5;
  localparam logic [2:0] MODE_BAD_BITMAP = 3'd6;
  localparam logic [2:0] MODE_BAD_MC_BMP = 3'd7;

  // Register indexes
  localparam logic [2:0] REG_BG_COLOR0    = 3'd0;
  localparam logic [2:0] REG_BG_COLOR1    = 3'd1;
  localparam logic [2:0] REG_BG_COLOR2    = 3'd2;
  localparam logic [2:0] REG_BG_COLOR3    = 3'd3;
  localparam logic [2:0] REG_WINDOW_FIRST = 3'd4;
  localparam logic [2:0] REG_WINDOW_LAST  = 3'd5;

  localparam logic [COL_W-1:0] WINDOW_FIRST_RST = 9'd24;
  localparam logic [COL_W-1:0] WINDOW_LAST_RST  = 9'd343;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         scroll_x;
    logic               first_cell;
    logic [7:0]         prev_pattern;
    logic [7:0]         cur_pattern;
    logic [7:0]         prev_screen_code;
    logic [7:0]         cur_screen_code;
    logic [3:0]         prev_color;
    logic [3:0]         cur_color;
    logic [COL_W-1:0]   cell_x;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_colors;
    logic [7:0]  pixel_written;
    logic [7:0]  foreground_mask;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       index;
    logic [COL_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [3:0][COLOR_W-1:0] bg_color;
    logic [COL_W-1:0]        window_first;
    logic [COL_W-1:0]        window_last;
  } cfg_regs_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               written;
    logic               fg;
  } lane_res_t;

  function automatic logic [COLOR_W-1:0] bg_pick(cfg_regs_t regs, logic [1:0] sel);
    return regs.bg_color[sel];
  endfunction

endpackage

@@ rtl/cbpg_stream_if.sv @@
interface cbpg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cbpg_lane.sv @@
module cbpg_lane (
  input  cbpg_pkg::in_item_t                 item_i,
  input  cbpg_pkg::cfg_regs_t                regs_i,
  input  logic [cbpg_pkg::PIX_IDX_W-1:0]     lane_idx_i,
  output cbpg_pkg::lane_res_t                res_o
);
  import cbpg_pkg::*;

  logic                 pair_mode;
  logic                 blank;
  logic [PIX_IDX_W-1:0] src_idx;
  logic                 use_prev;
  logic                 skip;
  logic [PIX_IDX_W-1:0] ofs;
  logic [7:0]           pat;
  logic [7:0]           sc;
  logic [3:0]           clr;
  logic [7:0]           pat_sh;
  logic [7:0]           pair_sh;
  logic                 pix_bit;
  logic [1:0]           cs;
  logic [COL_W:0]       pos;
  logic                 in_win;
  logic [COLOR_W-1:0]   color;
  logic                 wr;
  logic                 fg;

  // Pick the source character and bit offset for this pixel
  always_comb begin
    pair_mode = (item_i.mode == MODE_MC_TEXT) || (item_i.mode == MODE_MC_BITMAP) ||
                (item_i.mode == MODE_BAD_TEXT) || (item_i.mode == MODE_BAD_MC_BMP);
    blank     = (item_i.mode == MODE_BAD_TEXT) || (item_i.mode == MODE_BAD_BITMAP) ||
                (item_i.mode == MODE_BAD_MC_BMP);
    src_idx   = pair_mode ? {lane_idx_i[PIX_IDX_W-1:1], 1'b0} : lane_idx_i;
    use_prev  = src_idx < item_i.scroll_x;
    skip      = use_prev && item_i.first_cell;
    ofs       = src_idx - item_i.scroll_x;
    pat       = use_prev ? item_i.prev_pattern : item_i.cur_pattern;
    sc        = use_prev ? item_i.prev_screen_code : item_i.cur_screen_code;
    clr       = use_prev ? item_i.prev_color : item_i.cur_color;
    pat_sh    = pat << ofs;
    pair_sh   = pat << {ofs[PIX_IDX_W-1:1], 1'b0};
    pix_bit   = pat_sh[7];
    cs        = pair_sh[7:6];
  end

  // Window check on the unwrapped column
  always_comb begin
    pos    = {1'b0, item_i.cell_x} + (COL_W+1)'(lane_idx_i);
    in_win = (pos >= {1'b0, regs_i.window_first}) && (pos <= {1'b0, regs_i.window_last});
  end

  // Decode color, write and foreground for the mode
  always_comb begin
    color = clr;
    wr    = 1'b0;
    fg    = 1'b0;
    if (pair_mode) begin
      fg = !skip && cs[1];
      if (item_i.mode == MODE_MC_TEXT) begin
        if (!clr[3]) begin
          color = {1'b0, clr[2:0]};
          wr    = lane_idx_i[0] ? cs[0] : cs[1];
        end else begin
          color = (cs == 2'b11) ? {1'b0, clr[2:0]} : bg_pick(regs_i, cs);
          wr    = 1'b1;
        end
      end else begin
        unique case (cs)
          2'b01:   color = sc[7:4];
          2'b10:   color = sc[3:0];
          default: color = clr;
        endcase
        wr = 1'b1;
      end
      wr = wr && !skip && (cs != 2'b00) && !blank && in_win;
    end else if (item_i.mode == MODE_TEXT) begin
      color = clr;
      wr    = !skip && pix_bit && in_win;
      fg    = wr;
    end else begin
      fg = !skip && pix_bit;
      if (item_i.mode == MODE_EXT_BG) begin
        color = pix_bit ? clr : bg_pick(regs_i, sc[7:6]);
      end else begin
        color = pix_bit ? sc[7:4] : sc[3:0];
      end
      wr = !skip && !blank && in_win;
    end
  end

  assign res_o.color   = wr ? color : '0;
  assign res_o.written = wr;
  assign res_o.fg      = fg;

endmodule

@@ rtl/cbpg_merge.sv @@
`include "char_bitmap_cell_pixel_generator_core_macros.svh"

module cbpg_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  cbpg_pkg::lane_res_t [cbpg_pkg::NUM_PIXELS-1:0] lanes_i,
  cbpg_stream_if.source                               out_o
);
  import cbpg_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;
  logic      in_fire;
  logic      stray_color;

  assign in_ready_o = !valid_q || out_o.ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // Pack the lane results, pixel 0 in the top nibble and top mask bit
  always_comb begin
    data_d = data_q;
    if (in_fire) begin
      for (int l = 0; l < NUM_PIXELS; l++) begin
        data_d.pixel_colors[COLOR_W*(NUM_PIXELS-1-l) +: COLOR_W] = lanes_i[l].color;
        data_d.pixel_written[NUM_PIXELS-1-l]                    = lanes_i[l].written;
        data_d.foreground_mask[NUM_PIXELS-1-l]                  = lanes_i[l].fg;
      end
    end
  end

  // Hold the beat until taken, load a new one whenever there is room
  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

  // Flag any unwritten pixel that carries a color
  always_comb begin
    stray_color = 1'b0;
    for (int l = 0; l < NUM_PIXELS; l++) begin
      if (!data_q.pixel_written[NUM_PIXELS-1-l] &&
          (data_q.pixel_colors[COLOR_W*(NUM_PIXELS-1-l) +: COLOR_W] != '0)) begin
        stray_color = 1'b1;
      end
    end
  end

  `CBPG_ASSERT_NEXT(a_fire_gives_beat, clk_i, rst_ni, in_fire, valid_q)
  `CBPG_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, valid_q && !out_o.ready, !in_ready_o)
  `CBPG_ASSERT_NOW(a_unwritten_black, clk_i, rst_ni, valid_q, !stray_color)

endmodule

@@ rtl/char_bitmap_cell_pixel_generator_core.sv @@
// Graphics pixel generator for one 8-pixel raster cell. It takes one cell per
// clock: an input beat is accepted whenever the output register is empty or
// being drained, and its result appears on the output in the next cycle. Eight
// pixel lanes decode the cell side by side combinationally and a merge stage
// packs them into the output register, so throughput is one cell per clock
// while the output is not stalled. Configuration writes are always accepted;
// write them only while no cell is in flight.
`include "char_bitmap_cell_pixel_generator_core_macros.svh"

module char_bitmap_cell_pixel_generator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  cbpg_stream_if.sink   cfg_i,
  cbpg_stream_if.sink   in_i,
  cbpg_stream_if.source out_o
);
  import cbpg_pkg::*;

  cfg_regs_t                       regs_q, regs_d;
  lane_res_t [NUM_PIXELS-1:0]      lanes;
  cfg_write_t                      cfg_beat;
  in_item_t                        item;
  logic                            cfg_fire;

  assign cfg_beat    = cfg_i.data;
  assign item        = in_i.data;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Decode register writes
  always_comb begin
    regs_d = regs_q;
    if (cfg_fire) begin
      unique case (cfg_beat.index)
        REG_BG_COLOR0:    regs_d.bg_color[0]  = cfg_beat.data[COLOR_W-1:0];
        REG_BG_COLOR1:    regs_d.bg_color[1]  = cfg_beat.data[COLOR_W-1:0];
        REG_BG_COLOR2:    regs_d.bg_color[2]  = cfg_beat.data[COLOR_W-1:0];
        REG_BG_COLOR3:    regs_d.bg_color[3]  = cfg_beat.data[COLOR_W-1:0];
        REG_WINDOW_FIRST: regs_d.window_first = cfg_beat.data;
        REG_WINDOW_LAST:  regs_d.window_last  = cfg_beat.data;
        default:          regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.bg_color     <= '0;
      regs_q.window_first <= WINDOW_FIRST_RST;
      regs_q.window_last  <= WINDOW_LAST_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

  // One lane per pixel
  for (genvar l = 0; l < NUM_PIXELS; l++) begin : g_lane
    cbpg_lane u_lane (
      .item_i     (item),
      .regs_i     (regs_q),
      .lane_idx_i (PIX_IDX_W'(l)),
      .res_o      (lanes[l])
    );
  end

  // Combine lanes into the output register
  cbpg_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .lanes_i    (lanes),
    .out_o      (out_o)
  );

  `CBPG_ASSERT_NOW(a_cfg_always_ready, clk_i, rst_ni, cfg_i.valid, cfg_fire)
  `CBPG_ASSERT_NEXT(a_bad_index_ignored, clk_i, rst_ni,
    cfg_fire && (cfg_beat.index != REG_BG_COLOR0) && (cfg_beat.index != REG_BG_COLOR1) &&
    (cfg_beat.index != REG_BG_COLOR2) && (cfg_beat.index != REG_BG_COLOR3) &&
    (cfg_beat.index != REG_WINDOW_FIRST) && (cfg_beat.index != REG_WINDOW_LAST),
    $stable(regs_q))
  `CBPG_ASSERT_NEXT(a_idle_regs_hold, clk_i, rst_ni, !cfg_fire, $stable(regs_q))

endmodule
